[rtl/fifo_ftn_pkg.sv]
// package: codes, types and constants for the flush-timeout notify fifo
package fifo_ftn_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CAP_W          = 5;
    localparam int TMO_W          = 16;
    localparam int ELAPSED_W      = 17;
    localparam int LVL_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [CAP_W-1:0] CAP_MIN   = 5'd2;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 1'd0,
        REG_TIMEOUT  = 1'd1
    } t_reg_idx;

endpackage

[rtl/fifo_ftn_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module fifo_ftn_ram
    import fifo_ftn_pkg::*;
#(
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fifo_with_flush_timeout_notify_core.sv]
// top level: ring fifo with push/pop/tick items and flush-timeout notification
// result valid is registered in the cycle after the item is accepted
// one item per cycle unless stalled; ram read port and pointer update settle in that cycle
// input stall only while a result is held and the output is stalled
// reset: synchronous active low; clears pointers, tick counter, result valid,
// capacity to 16 and timeout to 0; ram contents are not cleared
module fifo_with_flush_timeout_notify_core
    import fifo_ftn_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_operation,
    input  logic [DATA_WIDTH-1:0] i_write_data,
    input  logic                  i_immediate,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [DATA_WIDTH-1:0] o_read_data,
    output logic                  o_notify,
    output logic [LVL_W-1:0]      o_fill_level,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int EXT_W = CAP_W + 1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    logic [CAP_W-1:0]     r_cap;
    logic [TMO_W-1:0]     r_tmo;
    logic [IDX_W-1:0]     r_widx, n_widx;
    logic [IDX_W-1:0]     r_ridx, n_ridx;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic                 r_notify, n_notify;
    logic                 r_pop_ok, n_pop_ok;
    logic [LVL_W-1:0]     r_level, n_level;

    logic                 in_acc;
    logic                 ram_we;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [EXT_W-1:0]     len;
    logic [EXT_W-1:0]     w_ext, r_ext, w_nxt, r_nxt, nw_ext, nr_ext;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 empty;
    t_op                  op;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign op         = t_op'(i_operation);

    // effective ring length
    always_comb begin
        len = EXT_W'(r_cap);
        if (r_cap < CAP_MIN) begin
            len = EXT_W'(CAP_MIN);
        end else if (32'(r_cap) > 32'(DEPTH)) begin
            len = EXT_W'(DEPTH);
        end
    end

    always_comb begin
        w_ext       = EXT_W'(r_widx);
        r_ext       = EXT_W'(r_ridx);
        w_nxt       = (w_ext + EXT_W'(1) >= len) ? '0 : w_ext + EXT_W'(1);
        r_nxt       = (r_ext + EXT_W'(1) >= len) ? '0 : r_ext + EXT_W'(1);
        empty       = (r_widx == r_ridx);
        elapsed_inc = (r_elapsed < ELAPSED_MAX) ? r_elapsed + ELAPSED_W'(1) : r_elapsed;

        n_widx    = r_widx;
        n_ridx    = r_ridx;
        n_elapsed = r_elapsed;
        n_status  = ST_OK;
        n_notify  = 1'b0;
        n_pop_ok  = 1'b0;
        ram_we    = 1'b0;

        unique case (op)
            OP_PUSH: begin
                if (w_nxt == r_ext) begin
                    n_status = ST_FULL;
                    n_notify = 1'b1;
                end else begin
                    ram_we   = in_acc;
                    n_widx   = IDX_W'(w_nxt);
                    n_notify = i_immediate;
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_ridx   = IDX_W'(r_nxt);
                end
            end
            OP_TICK: begin
                n_elapsed = elapsed_inc;
                if (!empty && elapsed_inc > ELAPSED_W'(r_tmo)) begin
                    n_notify  = 1'b1;
                    n_elapsed = '0;
                end
            end
            default: begin
            end
        endcase

        nw_ext = EXT_W'(n_widx);
        nr_ext = EXT_W'(n_ridx);
        // level after this item, indices always inside the ring
        if (nw_ext >= nr_ext) begin
            n_level = LVL_W'(nw_ext - nr_ext);
        end else begin
            n_level = LVL_W'(nw_ext + len - nr_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_tmo       <= '0;
            r_widx      <= '0;
            r_ridx      <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_widx    <= n_widx;
                r_ridx    <= n_ridx;
                r_elapsed <= n_elapsed;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_CAPACITY: begin
                        r_cap     <= i_cfg_data[CAP_W-1:0];
                        r_widx    <= '0;
                        r_ridx    <= '0;
                        r_elapsed <= '0;
                    end
                    REG_TIMEOUT: begin
                        r_tmo <= i_cfg_data[TMO_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_notify <= n_notify;
            r_pop_ok <= n_pop_ok;
            r_level  <= n_level;
        end
    end

    fifo_ftn_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (i_write_data),
        .i_re    (in_acc),
        .i_raddr (r_ridx),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_notify     = r_notify;
    assign o_fill_level = r_level;
    assign o_read_data  = r_pop_ok ? ram_rdata : '0;

    a_full_notifies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_notify)
        else $error("full push without notify");

    a_empty_pop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_read_data == '0 && !o_notify)
        else $error("empty pop returned data or notify");

    a_idx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EXT_W'(r_widx) < len && EXT_W'(r_ridx) < len)
        else $error("fifo index outside ring");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted item produced no result");

endmodule
